[sv/fog_volume_sphere_match_macros.svh]
// assertion macros shared by the fog volume sphere match rtl
// expects clk_i and rst_ni in the scope of use
`ifndef FOG_VOLUME_SPHERE_MATCH_MACROS_SVH
`define FOG_VOLUME_SPHERE_MATCH_MACROS_SVH

// same-cycle implication
`define FVSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FVSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fvsm_pkg.sv]
// shared types, widths and constants of the fog volume sphere match block
// no dependencies
package fvsm_pkg;

  localparam int COORD_W   = 32;  // q24.8 coordinate
  localparam int SUM_W     = 33;  // origin plus offset
  localparam int BND_W     = 34;  // sphere bound, center plus or minus radius
  localparam int RAD_W     = 31;
  localparam int ENTRY_W   = 6;
  localparam int FOG_IDX_W = 6;
  localparam int CFG_W     = 7;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;

  localparam int MAX_FOG_ENTRIES_DEF = 64;

  // register word index, paddr[2]
  localparam logic REG_FOG_COUNT = 1'b0;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  // sphere bounds carried down the chain
  typedef struct packed {
    logic [2:0][BND_W-1:0] lo;
    logic [2:0][BND_W-1:0] hi;
  } sphere_t;

  // token control bits passed cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

  // box load broadcast to every cell
  typedef struct packed {
    logic               we;
    logic [ENTRY_W-1:0] idx;
    vec3_t              low;
    vec3_t              high;
  } box_wr_t;

  function automatic logic [BND_W-1:0] sext_bnd(input logic [COORD_W-1:0] v);
    return {{(BND_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

[sv/fvsm_prep.sv]
// front end: forms sphere center, then low and high bounds per axis
// depends on fvsm_pkg
module fvsm_prep
  import fvsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  vec3_t            origin_i,
  input  vec3_t            offset_i,
  input  logic [RAD_W-1:0] radius_i,
  input  logic             no_world_i,
  output tok_ctl_t         ctl_o,
  output sphere_t          sph_o
);

  logic                  s1_valid_q;
  logic                  s1_no_world_q;
  logic [2:0][SUM_W-1:0] center_q;
  logic [RAD_W-1:0]      radius_q;
  tok_ctl_t              ctl_q;
  sphere_t               sph_q;
  sphere_t               sph_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sph_d.lo[j] = {center_q[j][SUM_W-1], center_q[j]}
                    - {{(BND_W-RAD_W){1'b0}}, radius_q};
      sph_d.hi[j] = {center_q[j][SUM_W-1], center_q[j]}
                    + {{(BND_W-RAD_W){1'b0}}, radius_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ctl_q      <= '0;
    end else begin
      s1_valid_q  <= start_i;
      ctl_q.valid <= s1_valid_q;
      ctl_q.found <= s1_no_world_q;  // no world: done, answer stays 0
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int j = 0; j < 3; j++) begin
        center_q[j] <= {origin_i[j][COORD_W-1], origin_i[j]}
                       + {offset_i[j][COORD_W-1], offset_i[j]};
      end
      radius_q      <= radius_i;
      s1_no_world_q <= no_world_i;
    end
    sph_q <= sph_d;
  end

  assign ctl_o = ctl_q;
  assign sph_o = sph_q;

endmodule

[sv/fvsm_cell.sv]
// one chain cell: holds one fog box and tests the passing sphere against it
// depends on fvsm_pkg
module fvsm_cell
  import fvsm_pkg::*;
#(
  parameter int MAX_FOG_ENTRIES = MAX_FOG_ENTRIES_DEF,
  parameter int CELL_IDX        = 1,
  localparam int IDX_W          = $clog2(MAX_FOG_ENTRIES),
  localparam int CNT_W          = $clog2(MAX_FOG_ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  box_wr_t          wr_i,
  input  logic [CNT_W-1:0] count_i,
  input  tok_ctl_t         ctl_i,
  input  logic [IDX_W-1:0] idx_i,
  input  sphere_t          sph_i,
  output tok_ctl_t         ctl_o,
  output logic [IDX_W-1:0] idx_o,
  output sphere_t          sph_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  vec3_t            low_q;
  vec3_t            high_q;
  tok_ctl_t         ctl_q;
  logic [IDX_W-1:0] idx_q;
  sphere_t          sph_q;
  logic [2:0]       axis_hit;
  logic             hit;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      axis_hit[j] = ($signed(sph_i.lo[j]) < $signed(sext_bnd(high_q[j])))
                 && ($signed(sph_i.hi[j]) > $signed(sext_bnd(low_q[j])));
    end
    hit = ctl_i.valid && !ctl_i.found && (MY_CNT < count_i) && (&axis_hit);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (int'(wr_i.idx) == CELL_IDX)) begin
      low_q  <= wr_i.low;
      high_q <= wr_i.high;
    end
    idx_q <= hit ? MY_IDX : idx_i;
    sph_q <= sph_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= ctl_i.valid;
      ctl_q.found <= ctl_i.found | hit;
    end
  end

  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign sph_o = sph_q;

endmodule

[sv/fog_volume_sphere_match.sv]
// top level of the fog volume sphere match block: handshakes, config, cell chain
// depends on fvsm_pkg, fvsm_prep, fvsm_cell and the macros header
//
//   channel  direction  handshake              words
//   in       input      in_valid_i/in_stall_o  box load (mode 0) or sphere query (mode 1)
//   out      output     out_valid_o/out_stall_i one fog_index per query, none per load
//   apb      input      psel/penable/pwrite    fog_count at byte address 0
//
// a load writes its cell in the cycle it is accepted
// a query's result is registered after two front-end stages, one cell per entry for entries
// 1 .. MAX_FOG_ENTRIES-1, then the output register
// one query walks the chain at a time and the chain frees in the same cycle the result is
// registered, so a new query is not taken until the last one has left the chain
// reset clears the control state and fog_count; fog boxes stay undefined until loaded
// a waiting result holds queries off but not loads
`include "fog_volume_sphere_match_macros.svh"

module fog_volume_sphere_match
  import fvsm_pkg::*;
#(
  parameter int MAX_FOG_ENTRIES = MAX_FOG_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [ENTRY_W-1:0]   entry_index_i,
  input  logic [COORD_W-1:0]   vec_a_x_i,
  input  logic [COORD_W-1:0]   vec_a_y_i,
  input  logic [COORD_W-1:0]   vec_a_z_i,
  input  logic [COORD_W-1:0]   vec_b_x_i,
  input  logic [COORD_W-1:0]   vec_b_y_i,
  input  logic [COORD_W-1:0]   vec_b_z_i,
  input  logic [RAD_W-1:0]     sphere_radius_i,
  input  logic                 no_world_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FOG_IDX_W-1:0] fog_index_o,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int IDX_W = $clog2(MAX_FOG_ENTRIES);
  localparam int CNT_W = $clog2(MAX_FOG_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FOG_ENTRIES);

  // config register
  logic [CFG_W-1:0] fog_count_q;
  logic             cfg_wr;
  logic [CNT_W-1:0] count_clamped;

  // handshake state
  logic                 in_accept;
  logic                 query_start;
  logic                 inflight_q;
  logic                 out_valid_q;
  logic [FOG_IDX_W-1:0] fog_index_q;

  box_wr_t box_wr;

  // chain taps: position 0 is the front end, the last is the tail
  tok_ctl_t             tok_ctl [MAX_FOG_ENTRIES];
  logic [IDX_W-1:0]     tok_idx [MAX_FOG_ENTRIES];
  sphere_t              tok_sph [MAX_FOG_ENTRIES];
  logic [MAX_FOG_ENTRIES-1:0] chain_vld;
  logic                 tail_valid;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FOG_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FOG_COUNT) begin
      prdata = PDATA_W'(fog_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fog_count_q <= '0;
    end else if (cfg_wr) begin
      fog_count_q <= pwdata[CFG_W-1:0];
    end
  end

  // counts above the table size scan the whole table
  assign count_clamped = (CMP_W'(fog_count_q) > MAX_CMP) ? CNT_W'(MAX_FOG_ENTRIES)
                                                         : CNT_W'(fog_count_q);

  // ---------------------------------------------------------------- input side
  // queries wait while one walks the chain or while a result sits stalled;
  // loads only wait on the walking query, since they touch the cells
  assign in_stall_o  = inflight_q || ((mode_i == MODE_QUERY) && out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign query_start = in_accept && (mode_i == MODE_QUERY);

  // loads beyond the table are dropped
  assign box_wr.we   = in_accept && (mode_i == MODE_LOAD)
                       && (int'(entry_index_i) < MAX_FOG_ENTRIES);
  assign box_wr.idx  = entry_index_i;
  assign box_wr.low  = {vec_a_z_i, vec_a_y_i, vec_a_x_i};
  assign box_wr.high = {vec_b_z_i, vec_b_y_i, vec_b_x_i};

  // ---------------------------------------------------------------- front end
  fvsm_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (query_start),
    .origin_i   ({vec_a_z_i, vec_a_y_i, vec_a_x_i}),
    .offset_i   ({vec_b_z_i, vec_b_y_i, vec_b_x_i}),
    .radius_i   (sphere_radius_i),
    .no_world_i (no_world_i),
    .ctl_o      (tok_ctl[0]),
    .sph_o      (tok_sph[0])
  );

  // answer defaults to the reserved entry
  assign tok_idx[0] = '0;

  // ---------------------------------------------------------------- cell chain
  // cell k holds entry k; the first hit latches and rides to the tail
  for (genvar k = 1; k < MAX_FOG_ENTRIES; k++) begin : g_cell
    fvsm_cell #(
      .MAX_FOG_ENTRIES (MAX_FOG_ENTRIES),
      .CELL_IDX        (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (box_wr),
      .count_i (count_clamped),
      .ctl_i   (tok_ctl[k-1]),
      .idx_i   (tok_idx[k-1]),
      .sph_i   (tok_sph[k-1]),
      .ctl_o   (tok_ctl[k]),
      .idx_o   (tok_idx[k]),
      .sph_o   (tok_sph[k])
    );
  end

  for (genvar k = 0; k < MAX_FOG_ENTRIES; k++) begin : g_vld
    assign chain_vld[k] = tok_ctl[k].valid;
  end

  assign tail_valid = tok_ctl[MAX_FOG_ENTRIES-1].valid;

  // ---------------------------------------------------------------- output side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (query_start) begin
        inflight_q <= 1'b1;
      end else if (tail_valid) begin
        inflight_q <= 1'b0;
      end
      if (tail_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_valid) begin
      fog_index_q <= FOG_IDX_W'(tok_idx[MAX_FOG_ENTRIES-1]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign fog_index_o = fog_index_q;

  // ---------------------------------------------------------------- checks
  `FVSM_ASSERT_IMP(a_one_token, 1'b1, $onehot0(chain_vld), "more than one query in the chain")
  `FVSM_ASSERT_IMP(a_tail_owned, tail_valid, inflight_q, "result with no query in flight")
  `FVSM_ASSERT_IMP(a_no_overrun, tail_valid, !(out_valid_q && out_stall_i),
                   "result arrives over a stalled word")
  `FVSM_ASSERT_NXT(a_start_flight, query_start, inflight_q && !out_valid_q,
                   "query start did not mark the chain busy")

endmodule

[test/fog_volume_sphere_match_test.sv]
// testbench for fog_volume_sphere_match: fog box loads and sphere queries against a predictor
// depends on fvsm_pkg and the fog_volume_sphere_match rtl, nothing else
// results are checked in order by a scoreboard class; tasks drive the word and apb ports
module fog_volume_sphere_match_test;
  import fvsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FOG_ENTRIES  = MAX_FOG_ENTRIES_DEF;
  // a query walks every cell, plus the two front-end stages and some margin
  localparam int DRAIN_CYCLES = FOG_ENTRIES + 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 95;
  // 64.0 in q24.8, the size of the region where most boxes and spheres live
  localparam int SPAN         = 16384;
  localparam logic [PADDR_W-1:0] FOG_COUNT_ADDR = {REG_FOG_COUNT, 2'b00};

  // widest centers that can still be split into two 32-bit operands
  localparam logic signed [BND_W-1:0] CENTER_MAX = 34'sh0_FFFF_FFFE;
  localparam logic signed [BND_W-1:0] CENTER_MIN = -34'sh1_0000_0000;
  localparam logic signed [BND_W-1:0] COORD_MAX  = 34'sh0_7FFF_FFFF;
  localparam logic signed [BND_W-1:0] COORD_MIN  = -34'sh0_8000_0000;

  // one input word, fields as the ports carry them
  typedef struct packed {
    logic                mode;
    logic [ENTRY_W-1:0]  entry;
    vec3_t               a;
    vec3_t               b;
    logic [RAD_W-1:0]    radius;
    logic                no_world;
  } fog_word_t;

  // keeps a copy of the fog table and fog_count, and the fog indexes still owed
  class fog_match_scoreboard;
    vec3_t                box_lo [FOG_ENTRIES];
    vec3_t                box_hi [FOG_ENTRIES];
    bit                   loaded [FOG_ENTRIES];
    logic [CFG_W-1:0]     fog_count;
    logic [FOG_IDX_W-1:0] pending_fog [$];
    int                   errors;

    function new();
      fog_count = '0;
      errors    = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    task report(string what);
      $display("%0t ns: %s", $time, what);
      errors++;
    endtask

    // first entry whose box overlaps the sphere on every axis, strictly
    function logic [FOG_IDX_W-1:0] first_overlap(fog_word_t w);
      logic signed [BND_W-1:0] ctr;
      logic signed [BND_W-1:0] rad;
      int                      scan;
      bit                      hit;
      if (w.no_world) return '0;
      scan = (fog_count > FOG_ENTRIES) ? FOG_ENTRIES : int'(fog_count);
      rad  = BND_W'(w.radius);
      for (int i = 1; i < scan; i++) begin
        hit = 1'b1;
        for (int ax = 0; ax < 3; ax++) begin
          ctr = BND_W'($signed(w.a[ax])) + BND_W'($signed(w.b[ax]));
          if (!((ctr - rad) < BND_W'($signed(box_hi[i][ax]))
                && (ctr + rad) > BND_W'($signed(box_lo[i][ax]))))
            hit = 1'b0;
        end
        if (hit) return FOG_IDX_W'(i);
      end
      return '0;
    endfunction

    function void note_word(fog_word_t w);
      if (w.mode == MODE_LOAD) begin
        if (w.entry < FOG_ENTRIES) begin
          box_lo[w.entry] = w.a;
          box_hi[w.entry] = w.b;
          loaded[w.entry] = 1'b1;
        end
      end else begin
        pending_fog.push_back(first_overlap(w));
      end
    endfunction

    task check_word(logic [FOG_IDX_W-1:0] got);
      logic [FOG_IDX_W-1:0] want;
      if (pending_fog.size() == 0) begin
        report($sformatf("fog_index %0d with no query waiting", got));
      end else begin
        want = pending_fog.pop_front();
        if (got !== want)
          report($sformatf("fog_index got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  // clock, reset and every block input start at a known value
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i          = MODE_LOAD;
  logic [ENTRY_W-1:0]   entry_index_i   = '0;
  logic [COORD_W-1:0]   vec_a_x_i       = '0;
  logic [COORD_W-1:0]   vec_a_y_i       = '0;
  logic [COORD_W-1:0]   vec_a_z_i       = '0;
  logic [COORD_W-1:0]   vec_b_x_i       = '0;
  logic [COORD_W-1:0]   vec_b_y_i       = '0;
  logic [COORD_W-1:0]   vec_b_z_i       = '0;
  logic [RAD_W-1:0]     sphere_radius_i = '0;
  logic                 no_world_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [FOG_IDX_W-1:0] fog_index_o;
  logic                 psel            = 1'b0;
  logic                 penable         = 1'b0;
  logic                 pwrite          = 1'b0;
  logic [PADDR_W-1:0]   paddr           = '0;
  logic [PDATA_W-1:0]   pwdata          = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  fog_match_scoreboard sb;
  // when set, neither side idles: back-to-back stretches
  bit                  steady = 1'b0;
  int unsigned         cycle_count = 0;
  logic [CFG_W-1:0]    count_plan [9] = '{7'd64, 7'd127, 7'd2, 7'd17, 7'd0, 7'd65, 7'd1,
                                          7'd40, 7'd5};

  fog_volume_sphere_match #(
    .MAX_FOG_ENTRIES(FOG_ENTRIES)
  ) u_top (.*);

  always #10 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: every accepted word is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(fog_index_o);
  end

  // result side back-pressure: a random stall before each word, none in steady stretches
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      // out_stall_i is low at this edge, so a valid word is taken here
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // mostly scene-sized values, some full range, some at the extremes
  function automatic logic [COORD_W-1:0] scene_coord();
    return $urandom_range(0, 2 * SPAN) - SPAN;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return scene_coord();
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return RAD_W'($urandom);
      default: return RAD_W'($urandom_range(0, SPAN / 2));
    endcase
  endfunction

  function automatic vec3_t vec(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic fog_word_t word(input logic mode, input logic [ENTRY_W-1:0] entry,
                                     input vec3_t a, input vec3_t b,
                                     input logic [RAD_W-1:0] radius, input logic no_world);
    fog_word_t w;
    w.mode     = mode;
    w.entry    = entry;
    w.a        = a;
    w.b        = b;
    w.radius   = radius;
    w.no_world = no_world;
    return w;
  endfunction

  // present one word after a random gap and hold it until taken
  // valid stays high into the next word when there is no gap
  task automatic send_word(input fog_word_t w);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i          <= w.mode;
    entry_index_i   <= w.entry;
    vec_a_x_i       <= w.a[0];
    vec_a_y_i       <= w.a[1];
    vec_a_z_i       <= w.a[2];
    vec_b_x_i       <= w.b[0];
    vec_b_y_i       <= w.b[1];
    vec_b_z_i       <= w.b[2];
    sphere_radius_i <= w.radius;
    no_world_i      <= w.no_world;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  // stop sending, collect every owed result, then let a trailing load settle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_fog.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_fog_count(input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FOG_COUNT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.fog_count = value;
  endtask

  initial begin
    fog_word_t               w;
    int                      scan;
    int                      hole;
    int                      tgt;
    int                      nudge;
    logic [COORD_W-1:0]      lo;
    logic [COORD_W-1:0]      size;
    logic [COORD_W-1:0]      off;
    logic signed [BND_W-1:0] lo34;
    logic signed [BND_W-1:0] hi34;
    logic signed [BND_W-1:0] rad34;
    logic signed [BND_W-1:0] ctr;
    logic signed [BND_W-1:0] part;
    logic signed [BND_W-1:0] rest;

    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fog_count is zero out of reset: nothing scanned, answers are 0
    send_word(word(MODE_QUERY, 6'd0, vec(0, 0, 0), vec(0, 0, 0), '0, 1'b0));
    send_word(word(MODE_QUERY, '1, vec('1 >> 1, '1 >> 1, '1 >> 1), vec('1 >> 1, '1 >> 1, '1 >> 1),
                   '1, 1'b0));
    // plain box around the origin, an inverted box, the widest box, then entry 0 and the top
    send_word(word(MODE_LOAD, 6'd1, vec(-256, -256, -256), vec(256, 256, 256), '0, 1'b0));
    send_word(word(MODE_LOAD, 6'd2, vec(1000, 1000, 1000), vec(-1000, -1000, -1000), '0, 1'b0));
    send_word(word(MODE_LOAD, 6'd3, vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                   vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), '1, 1'b1));
    send_word(word(MODE_LOAD, 6'd0, vec(-8, -8, -8), vec(8, 8, 8), '0, 1'b0));
    send_word(word(MODE_LOAD, 6'd63, vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                   vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), '0, 1'b0));
    settle();

    // a count of one scans nothing either
    write_fog_count(7'd1);
    send_word(word(MODE_QUERY, 6'd0, vec(0, 0, 0), vec(0, 0, 0), '0, 1'b0));
    settle();

    // entries 1 .. 3 in play: strict edges, no_world, wide sums
    write_fog_count(7'd4);
    send_word(word(MODE_QUERY, 6'd0, vec(0, 0, 0), vec(0, 0, 0), '0, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(256, 0, 0), vec(0, 0, 0), '0, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(200, 0, 0), vec(55, 0, 0), '0, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(-300, 0, 0), vec(0, 0, 0), 31'd44, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(-300, 0, 0), vec(0, 0, 0), 31'd45, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(0, 0, 0), vec(0, 0, 0), '0, 1'b1));
    send_word(word(MODE_QUERY, 6'd0, vec(32'h7FFF_FFFF, 0, 0), vec(32'h7FFF_FFFF, 0, 0), '1, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(32'h7FFF_FFFF, 0, 0), vec(32'h8000_0001, 0, 0), '0, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                   vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), '0, 1'b0));
    send_word(word(MODE_QUERY, 6'd0, vec(0, 0, 0), vec(0, 0, 0), '1, 1'b0));
    settle();

    // random phases, one fog_count setting each, extremes and oversized counts among them
    count_plan[8] = CFG_W'($urandom_range(0, 127));
    for (int p = 0; p < 9; p++) begin
      write_fog_count(count_plan[p]);
      scan = (count_plan[p] > FOG_ENTRIES) ? FOG_ENTRIES : int'(count_plan[p]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k % 20 == 0) steady = ($urandom_range(0, 4) == 0);
        // a query must never scan an entry that was never loaded
        hole = 0;
        for (int i = scan - 1; i >= 1; i--) if (!sb.loaded[i]) hole = i;
        w.entry    = ENTRY_W'($urandom);
        w.radius   = rand_radius();
        w.no_world = ($urandom_range(0, 9) == 0);
        if (hole != 0 || $urandom_range(0, 99) < 35) begin
          // load: mostly sane boxes in the scene, some inverted, some anything
          w.mode = MODE_LOAD;
          if (hole != 0) w.entry = ENTRY_W'(hole);
          for (int ax = 0; ax < 3; ax++) begin
            lo   = scene_coord();
            size = $urandom_range(0, SPAN / 2);
            case ($urandom_range(0, 9))
              0: begin
                w.a[ax] = rand_coord();
                w.b[ax] = rand_coord();
              end
              1: begin
                w.a[ax] = lo + size;
                w.b[ax] = lo;
              end
              default: begin
                w.a[ax] = lo;
                w.b[ax] = lo + size;
              end
            endcase
          end
        end else begin
          w.mode = MODE_QUERY;
          if (scan >= 2 && $urandom_range(0, 1) == 1) begin
            // aim at a loaded box: just past, on, or just inside a face, or its middle
            tgt   = $urandom_range(1, scan - 1);
            rad34 = BND_W'(w.radius);
            for (int ax = 0; ax < 3; ax++) begin
              lo34  = BND_W'($signed(sb.box_lo[tgt][ax]));
              hi34  = BND_W'($signed(sb.box_hi[tgt][ax]));
              nudge = int'($urandom_range(0, 2)) - 1;
              case ($urandom_range(0, 3))
                0: ctr = hi34 + rad34 + BND_W'(nudge);
                1: ctr = lo34 - rad34 + BND_W'(nudge);
                default: ctr = ((lo34 + hi34) >>> 1) + BND_W'(nudge);
              endcase
              if (ctr > CENTER_MAX) ctr = CENTER_MAX;
              if (ctr < CENTER_MIN) ctr = CENTER_MIN;
              // split the center into origin and offset
              off  = scene_coord();
              part = ctr - BND_W'($signed(off));
              if ($urandom_range(0, 1) == 1 && part >= COORD_MIN && part <= COORD_MAX) begin
                w.a[ax] = part[COORD_W-1:0];
                w.b[ax] = off;
              end else begin
                part    = ctr >>> 1;
                rest    = ctr - part;
                w.a[ax] = part[COORD_W-1:0];
                w.b[ax] = rest[COORD_W-1:0];
              end
            end
          end else begin
            for (int ax = 0; ax < 3; ax++) begin
              w.a[ax] = rand_coord();
              w.b[ax] = rand_coord();
            end
          end
        end
        send_word(w);
      end
      steady = 1'b0;
      settle();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
